### hdl/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants for the matrix-vector multiplier.
// ----------------------------------------------------------------------------
package mvm_pkg;

   localparam int MAX_SIZE_DEFAULT = 1024;
   localparam int QUEUE_DEPTH      = 4;

   localparam int VALUE_W    = 32;
   localparam int SUM_W      = 64;
   localparam int ROW_IDX_W  = 10;
   localparam int SIZE_W     = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 80;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   // register index taken from paddr[2]
   localparam logic CSR_IDX_SIZE = 1'b0;

   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_MATRIX = 1'b1;

   // one matrix element with its vector operand, front to back
   typedef struct packed {
      logic [VALUE_W-1:0]   value;
      logic [VALUE_W-1:0]   vec;
      logic                 last_col;
      logic [ROW_IDX_W-1:0] row_index;
      logic                 last_row;
   } entry_type;

endpackage

### hdl/mvm_ram.sv
// ----------------------------------------------------------------------------
// mvm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mvm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/mvm_front.sv
// ----------------------------------------------------------------------------
// mvm_front
// Accepts transactions, writes vector elements, fetches the vector operand
// for matrix elements and hands them to the queue with row bookkeeping.
// ----------------------------------------------------------------------------
module mvm_front #(
   parameter int MAX_SIZE = mvm_pkg::MAX_SIZE_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic [$clog2(MAX_SIZE)-1:0] size_m1,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic                        req_tuser,
   input  logic [mvm_pkg::VALUE_W-1:0] req_value,
   input  logic [$clog2(mvm_pkg::QUEUE_DEPTH+1)-1:0] q_count,
   output logic                        q_push,
   output mvm_pkg::entry_type          q_entry
);

   localparam int AW = $clog2(MAX_SIZE);
   localparam int CW = $clog2(mvm_pkg::QUEUE_DEPTH + 1);

   logic [AW-1:0] load_idx_ff, load_idx_in;
   logic [AW-1:0] col_ff, col_in;
   logic [AW-1:0] row_ff, row_in;

   logic                             s1_valid_ff, s1_valid_in;
   logic [mvm_pkg::VALUE_W-1:0]      s1_value_ff;
   logic                             s1_last_col_ff;
   logic [mvm_pkg::ROW_IDX_W-1:0]    s1_row_ff;
   logic                             s1_last_row_ff;

   logic                        accept, load_go, mat_go;
   logic                        last_col, last_row;
   logic [31:0]                 row_wide;
   logic [mvm_pkg::VALUE_W-1:0] vec_rd;
   logic [CW:0]                 used;

   // room for the queue plus the element still in the fetch stage
   assign used       = {1'b0, q_count} + {{CW{1'b0}}, s1_valid_ff};
   assign req_tready = (used < (CW+1)'(mvm_pkg::QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign load_go    = accept && (req_tuser == mvm_pkg::ACT_LOAD);
   assign mat_go     = accept && (req_tuser == mvm_pkg::ACT_MATRIX);

   assign last_col = (col_ff == size_m1);
   assign last_row = (row_ff == size_m1);
   assign row_wide = 32'(row_ff);

   always_comb begin
      load_idx_in = load_idx_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (load_go) begin
         load_idx_in = (load_idx_ff == size_m1) ? '0 : load_idx_ff + 1'b1;
      end
      if (mat_go) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      if (clear) begin
         load_idx_in = '0;
         col_in      = '0;
         row_in      = '0;
      end
   end

   assign s1_valid_in = mat_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_idx_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         load_idx_ff <= load_idx_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mat_go) begin
         s1_value_ff    <= req_value;
         s1_last_col_ff <= last_col;
         s1_row_ff      <= row_wide[mvm_pkg::ROW_IDX_W-1:0];
         // only the closing element of the final row carries the flag
         s1_last_row_ff <= last_row && last_col;
      end
   end

   mvm_ram #(
      .WIDTH (mvm_pkg::VALUE_W),
      .DEPTH (MAX_SIZE)
   ) u_vec_store (
      .clock   (clock),
      .wr_en   (load_go),
      .wr_addr (load_idx_ff),
      .wr_data (req_value),
      .rd_en   (mat_go),
      .rd_addr (col_ff),
      .rd_data (vec_rd)
   );

   assign q_push            = s1_valid_ff;
   assign q_entry.value     = s1_value_ff;
   assign q_entry.vec       = vec_rd;
   assign q_entry.last_col  = s1_last_col_ff;
   assign q_entry.row_index = s1_row_ff;
   assign q_entry.last_row  = s1_last_row_ff;

endmodule

### hdl/mvm_queue.sv
// ----------------------------------------------------------------------------
// mvm_queue
// Short register FIFO that decouples the fetch front from the MAC back.
// ----------------------------------------------------------------------------
module mvm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mvm_pkg::entry_type   push_entry,
   input  logic                 pop,
   output logic                 head_valid,
   output mvm_pkg::entry_type   head_entry,
   output logic [$clog2(mvm_pkg::QUEUE_DEPTH+1)-1:0] count
);

   localparam int DEPTH = mvm_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   mvm_pkg::entry_type slot_ff [DEPTH];
   logic [PW-1:0] wptr_ff, wptr_in;
   logic [PW-1:0] rptr_ff, rptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_entry;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rptr_ff];
   assign count      = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff < CW'(DEPTH))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue underflow");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wptr_ff == rptr_ff)
      else $error("queue pointers disagree with empty count");

endmodule

### hdl/mvm_back.sv
// ----------------------------------------------------------------------------
// mvm_back
// Multiplies each matrix element by its vector operand, accumulates the row
// with saturation and holds the finished row sum in an output register.
// ----------------------------------------------------------------------------
module mvm_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            clear,
   input  logic                            head_valid,
   input  mvm_pkg::entry_type              head_entry,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mvm_pkg::SUM_W-1:0]       rsp_sum,
   output logic [mvm_pkg::ROW_IDX_W-1:0]   rsp_row,
   output logic                            rsp_tlast
);

   localparam int SW = mvm_pkg::SUM_W;

   logic signed [mvm_pkg::VALUE_W-1:0] mul_a, mul_b;
   logic signed [SW-1:0]               prod_in;

   logic                            m_valid_ff, m_valid_in;
   logic signed [SW-1:0]            m_prod_ff;
   logic                            m_last_col_ff;
   logic [mvm_pkg::ROW_IDX_W-1:0]   m_row_ff;
   logic                            m_last_row_ff;

   logic signed [SW-1:0]            acc_ff, acc_in;
   logic [SW-1:0]                   sum_raw, sum_sat;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]                   rsp_sum_ff;
   logic [mvm_pkg::ROW_IDX_W-1:0]   rsp_row_ff;
   logic                            rsp_last_ff;

   logic out_free, m_fire, m_open, emit;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign m_fire   = m_valid_ff && (!m_last_col_ff || out_free);
   assign m_open   = !m_valid_ff || m_fire;
   assign pop      = head_valid && m_open;
   assign emit     = m_fire && m_last_col_ff;

   assign mul_a   = $signed(head_entry.value);
   assign mul_b   = $signed(head_entry.vec);
   assign prod_in = mul_a * mul_b;

   // saturate when both operands share a sign that the sum lost
   assign sum_raw = acc_ff + m_prod_ff;
   always_comb begin
      sum_sat = sum_raw;
      if ((acc_ff[SW-1] == m_prod_ff[SW-1]) && (sum_raw[SW-1] != acc_ff[SW-1])) begin
         sum_sat = acc_ff[SW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end
   end

   always_comb begin
      m_valid_in = m_open ? head_valid : m_valid_ff;
      acc_in     = acc_ff;
      if (m_fire) begin
         acc_in = m_last_col_ff ? '0 : $signed(sum_sat);
      end
      if (clear) begin
         acc_in = '0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         m_valid_ff   <= m_valid_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         m_prod_ff     <= prod_in;
         m_last_col_ff <= head_entry.last_col;
         m_row_ff      <= head_entry.row_index;
         m_last_row_ff <= head_entry.last_row;
      end
      if (emit) begin
         rsp_sum_ff  <= sum_sat;
         rsp_row_ff  <= m_row_ff;
         rsp_last_ff <= m_last_row_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_sum    = rsp_sum_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      emit |=> acc_ff == '0)
      else $error("accumulator not cleared after row");

   a_rsp_from_row_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(emit))
      else $error("result raised without a finished row");

   a_last_row_ends_row: assert property (@(posedge clock) disable iff (reset)
      m_valid_ff && m_last_row_ff |-> m_last_col_ff)
      else $error("last row flagged on an inner column");

endmodule

### hdl/matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Streaming y = A*v for a square matrix of configurable size, Q16.16 inputs
// and saturated Q32.32 row sums.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while req_tready is high, vector loads (tuser 0) and matrix elements
// (tuser 1) alike, in any mix. A matrix element reads its vector operand from
// an on-chip store in the cycle it is accepted, passes a four-entry queue and
// then one 32x32 multiply stage and one 64-bit saturating accumulate stage;
// the finished row sum is registered and held on the result port. The
// request side only stalls when the result side holds off long enough to
// fill the queue. Load the vector before streaming rows that use it.
// Writing size_in_use restarts load, column and row counting.
// ----------------------------------------------------------------------------
module matrix_vector_multiply #(
   parameter int MAX_SIZE = mvm_pkg::MAX_SIZE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // streaming request
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mvm_pkg::REQ_DATA_W-1:0]   req_tdata,   // [31:0] value
   input  logic                             req_tuser,   // [0] action
   // streaming result
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mvm_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [63:0] row_sum, [73:64] row_index
   output logic                             rsp_tlast,   // last_row
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mvm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mvm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mvm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int AW = $clog2(MAX_SIZE);

   logic [mvm_pkg::SIZE_W-1:0] size_ff, size_in;
   logic                       size_wr;
   logic [31:0]                n_wide, n_eff;
   logic [AW-1:0]              size_m1;

   logic                                            q_push, q_pop, q_valid;
   mvm_pkg::entry_type                              q_in, q_head;
   logic [$clog2(mvm_pkg::QUEUE_DEPTH+1)-1:0]       q_count;
   logic [mvm_pkg::SUM_W-1:0]                       rsp_sum;
   logic [mvm_pkg::ROW_IDX_W-1:0]                   rsp_row;

   assign csr_pready = 1'b1;
   assign size_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == mvm_pkg::CSR_IDX_SIZE);
   assign size_in    = size_wr ? csr_pwdata[mvm_pkg::SIZE_W-1:0] : size_ff;
   assign csr_prdata = (csr_paddr[2] == mvm_pkg::CSR_IDX_SIZE) ?
                       32'(size_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= mvm_pkg::SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   // zero acts as one, anything past the store depth is capped
   assign n_wide = 32'(size_ff);
   always_comb begin
      n_eff = n_wide;
      if (n_wide == 32'd0) begin
         n_eff = 32'd1;
      end else if (n_wide > 32'(MAX_SIZE)) begin
         n_eff = 32'(MAX_SIZE);
      end
   end
   assign size_m1 = AW'(n_eff - 32'd1);

   mvm_front #(
      .MAX_SIZE (MAX_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .clear      (size_wr),
      .size_m1    (size_m1),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_value  (req_tdata[mvm_pkg::VALUE_W-1:0]),
      .q_count    (q_count),
      .q_push     (q_push),
      .q_entry    (q_in)
   );

   mvm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head),
      .count      (q_count)
   );

   mvm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .clear      (size_wr),
      .head_valid (q_valid),
      .head_entry (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_sum    (rsp_sum),
      .rsp_row    (rsp_row),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, rsp_row, rsp_sum};

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming matrix-vector multiplier: drives
// vector loads and matrix elements under random size settings, predicts each
// saturated row sum and compares every result transaction in order.
// ----------------------------------------------------------------------------
module tb;
   import mvm_pkg::*;

   localparam int STORE_DEPTH = MAX_SIZE_DEFAULT;
   localparam int LIMIT       = 400000;
   localparam int SETTLE      = 16;
   localparam logic [CSR_ADDR_W-1:0] SIZE_ADDR = {CSR_IDX_SIZE, 2'b00};
   localparam logic signed [SUM_W-1:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [SUM_W-1:0]     row_sum;
      logic [ROW_IDX_W-1:0] row_index;
      logic                 last_row;
   } row_result_type;

   // running dot products of the streamed matrix with the loaded vector
   class row_sum_board;
      logic [VALUE_W-1:0]      vec_copy [STORE_DEPTH];
      bit                      filled [STORE_DEPTH];
      int unsigned             n_eff, load_at, col_at, row_at;
      logic signed [SUM_W-1:0] acc;
      row_result_type          rows_due [$];
      int unsigned             errors, rows_seen, sat_hits;

      function new();
         set_size(SIZE_RESET);
      endfunction

      function void set_size(logic [SIZE_W-1:0] sz);
         n_eff   = (sz == 0) ? 1 : ((sz > STORE_DEPTH) ? STORE_DEPTH : sz);
         load_at = 0;
         col_at  = 0;
         row_at  = 0;
         acc     = '0;
      endfunction

      function bit covers(int unsigned n);
         for (int i = 0; i < n; i++) if (!filled[i]) return 1'b0;
         return 1'b1;
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) $display("mismatch: %s", msg);
      endfunction

      function void note_transaction(logic act, logic [VALUE_W-1:0] value);
         logic signed [SUM_W-1:0] a, x, prod, total;
         row_result_type r;
         if (act == ACT_LOAD) begin
            vec_copy[load_at] = value;
            filled[load_at]   = 1'b1;
            load_at = (load_at + 1 >= n_eff) ? 0 : load_at + 1;
            return;
         end
         a     = SUM_W'($signed(value));
         x     = SUM_W'($signed(vec_copy[col_at]));
         prod  = a * x;
         total = acc + prod;
         if (acc[SUM_W-1] == prod[SUM_W-1] && total[SUM_W-1] != acc[SUM_W-1]) begin
            total = acc[SUM_W-1] ? SUM_MIN : SUM_MAX;
            sat_hits++;
         end
         acc = total;
         if (col_at + 1 < n_eff) begin
            col_at++;
            return;
         end
         r.row_sum   = acc;
         r.row_index = ROW_IDX_W'(row_at);
         r.last_row  = (row_at + 1 == n_eff);
         rows_due.push_back(r);
         acc    = '0;
         col_at = 0;
         row_at = (row_at + 1 >= n_eff) ? 0 : row_at + 1;
      endfunction

      function void check_row(logic [SUM_W-1:0] sum, logic [ROW_IDX_W-1:0] idx,
                              logic last);
         row_result_type want;
         if (rows_due.size() == 0) begin
            report($sformatf("row sum %h for row %0d with nothing expected", sum, idx));
            return;
         end
         want = rows_due.pop_front();
         rows_seen++;
         if (sum !== want.row_sum || idx !== want.row_index || last !== want.last_row)
            report($sformatf("expected sum %h row %0d last %0b, got sum %h row %0d last %0b",
                             want.row_sum, want.row_index, want.last_row, sum, idx, last));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [31:0] value
   logic                  req_tuser = 1'b0; // [0] action
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [63:0] row_sum, [73:64] row_index
   logic                  rsp_tlast;        // last_row
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   row_sum_board board = new();
   bit           idle_on = 1'b1;
   int           hold_left = 0;
   int unsigned  sent, sizes_tried, cycles;

   matrix_vector_multiply uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles == LIMIT) begin
         $display("timed out after %0d cycles", cycles);
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_transaction(req_tuser, req_tdata[VALUE_W-1:0]);
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_row(rsp_tdata[SUM_W-1:0], rsp_tdata[SUM_W+ROW_IDX_W-1:SUM_W], rsp_tlast);
   end

   // result side: random stalls plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= !(idle_on && $urandom_range(0, 99) < 28);
      end
   end

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(input logic act, input logic [VALUE_W-1:0] value);
      while (idle_on && $urandom_range(0, 99) < 28) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task automatic check_size_reg(input logic [SIZE_W-1:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= SIZE_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[SIZE_W-1:0] !== want)
         board.report($sformatf("size_in_use read %0d, expected %0d",
                                csr_prdata[SIZE_W-1:0], want));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] sz);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SIZE_ADDR;
      csr_pwdata  <= CSR_DATA_W'(sz);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.set_size(sz);
      @(negedge clock);
      // psel stays up: the readback starts right here with its setup cycle
      check_size_reg(sz);
   endtask

   // partial rows leave work in flight without a result, hence the settle time
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.rows_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic new_size(input logic [SIZE_W-1:0] sz);
      wait_idle();
      write_size(sz);
      sizes_tried++;
   endtask

   initial begin
      int unsigned       n, rows, phase;
      logic [SIZE_W-1:0] sz;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      check_size_reg(SIZE_RESET);

      // positive saturation, mixed signs, a load inside a row, row wrap
      new_size(SIZE_W'(2));
      send_item(ACT_LOAD, 32'h8000_0000);
      send_item(ACT_LOAD, 32'h8000_0000);
      send_item(ACT_MATRIX, 32'h8000_0000);
      send_item(ACT_MATRIX, 32'h8000_0000);
      send_item(ACT_MATRIX, 32'h7FFF_FFFF);
      send_item(ACT_MATRIX, 32'h8000_0000);
      send_item(ACT_MATRIX, 32'h0000_0000);
      send_item(ACT_LOAD, 32'h0001_0000);
      send_item(ACT_MATRIX, 32'hFFFF_FFFF);

      // negative saturation, then a row and a load cut short by a size write
      new_size(SIZE_W'(3));
      repeat (3) send_item(ACT_LOAD, 32'h7FFF_FFFF);
      repeat (3) send_item(ACT_MATRIX, 32'h8000_0000);
      send_item(ACT_MATRIX, 32'h1234_5678);
      send_item(ACT_LOAD, 32'h0000_0001);

      // size zero behaves as one: every element is a whole matrix
      new_size(SIZE_W'(0));
      send_item(ACT_LOAD, 32'hFFFF_0000);
      send_item(ACT_MATRIX, 32'h7FFF_FFFF);
      send_item(ACT_MATRIX, 32'h8000_0000);

      // largest register value and the reset size, partial rows only
      new_size('1);
      repeat (8) send_item(ACT_LOAD, pick_value());
      repeat (4) send_item(ACT_MATRIX, pick_value());
      new_size(SIZE_RESET);
      repeat ($urandom_range(1, 8)) send_item(ACT_LOAD, pick_value());
      repeat ($urandom_range(1, 8)) send_item(ACT_MATRIX, pick_value());

      phase = 0;
      while (sent < 1300) begin
         phase++;
         idle_on = !(phase >= 4 && phase <= 8);
         case ($urandom_range(0, 9))
            0:       sz = SIZE_W'($urandom_range(0, 1));
            1, 2:    sz = SIZE_W'($urandom_range(9, 40));
            default: sz = SIZE_W'($urandom_range(2, 8));
         endcase
         if (phase == 10) sz = SIZE_W'(1);
         new_size(sz);
         n = board.n_eff;
         if (!board.covers(n) || $urandom_range(0, 2) == 0)
            repeat (n) send_item(ACT_LOAD, pick_value());
         rows = (n <= 8) ? $urandom_range(1, 12) : $urandom_range(1, 3);
         if (phase == 10) begin
            // results back up while requests keep coming
            hold_left = 200;
            rows = 60;
         end
         repeat (rows * n) begin
            if ($urandom_range(0, 9) == 0) send_item(ACT_LOAD, pick_value());
            send_item(ACT_MATRIX, pick_value());
         end
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(0, n - 1)) send_item(ACT_MATRIX, pick_value());
            repeat ($urandom_range(0, 2)) send_item(ACT_LOAD, pick_value());
         end
      end
      idle_on = 1'b1;
      wait_idle();

      $display("%0d transactions driven, %0d row sums checked over %0d size settings",
               sent, board.rows_seen, sizes_tried);
      $display("%0d saturating adds, one 200-cycle result hold-off, %0d mismatches",
               board.sat_hits, board.errors);
      if (board.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
